>>> rtl/tcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcb_pkg
// Shared types, codes and helpers for the transpose and clip buffer.
// ----------------------------------------------------------------------------
package tcb_pkg;

	localparam int TCB_DEPTH = 65536;

	localparam int DIM_W    = 13;      // raw dimension register width
	localparam int POS_W    = 12;      // block / sample position counters
	localparam int PROD_W   = 25;      // rows * cols, up to 4096 * 4096
	localparam int DATA_W   = 16;
	localparam int CFG_IW   = 3;
	localparam int STATUS_W = 2;

	localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(4096);

	// configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_ROW_COUNT     = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_COL_COUNT     = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_LOW_LIMIT     = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_HIGH_LIMIT    = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_FILL_VALUE    = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_CEILING_VALUE = 3'd5;

	// item modes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_PASS = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FILL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CEIL = 2'd2;

	typedef struct packed {
		logic signed [DATA_W-1:0] low_limit;
		logic signed [DATA_W-1:0] high_limit;
		logic signed [DATA_W-1:0] fill_value;
		logic signed [DATA_W-1:0] ceiling_value;
	} tcb_limits_t;

	// control that travels with a store read
	typedef struct packed {
		logic valid;
		logic last;
	} tcb_rd_t;

	// zero dimension counts as 1, oversized clamps to 4096
	function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] raw);
		logic [DIM_W-1:0] d;
		if (raw == '0) begin
			d = DIM_W'(1);
		end else if (raw > MAX_DIM) begin
			d = MAX_DIM;
		end else begin
			d = raw;
		end
		return d;
	endfunction

endpackage
`default_nettype wire

>>> rtl/tcb_clip.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcb_clip
// Limit substitution on a value read from the grid store, with the result
// register that drives the output strobe.
// ----------------------------------------------------------------------------
module tcb_clip (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire tcb_pkg::tcb_rd_t                 rd,
	input  wire logic signed [tcb_pkg::DATA_W-1:0] rd_data,
	input  wire tcb_pkg::tcb_limits_t             limits,
	output logic                                  strobe,
	output logic signed [tcb_pkg::DATA_W-1:0]     value,
	output logic [tcb_pkg::STATUS_W-1:0]          status,
	output logic                                  last
);
	import tcb_pkg::*;

	logic signed [DATA_W-1:0] value_d;
	logic [STATUS_W-1:0]      status_d;
	logic                     strobe_q;
	logic signed [DATA_W-1:0] value_q;
	logic [STATUS_W-1:0]      status_q;
	logic                     last_q;

	// low limit wins over high limit when both apply
	always_comb begin
		if (rd_data < limits.low_limit) begin
			value_d  = limits.fill_value;
			status_d = ST_FILL;
		end else if (rd_data > limits.high_limit) begin
			value_d  = limits.ceiling_value;
			status_d = ST_CEIL;
		end else begin
			value_d  = rd_data;
			status_d = ST_PASS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= rd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.valid) begin
			value_q  <= value_d;
			status_q <= status_d;
			last_q   <= rd.last;
		end
	end

	assign strobe = strobe_q;
	assign value  = value_q;
	assign status = status_q;
	assign last   = last_q;

endmodule
`default_nettype wire

>>> rtl/transpose_and_clip_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// transpose_and_clip_buffer
// Corner-turn buffer: loads a grid row-major, drains it transposed with
// low/high limit substitution.
// ----------------------------------------------------------------------------
// One item is taken every clock; busy is held low. A load item is held in
// the item register and then writes the store. A drain item that finds the
// grid complete passes through the item register, the store read register and
// the clip result register, then raises strobe for one cycle with its result
// on value/status/last. The receiver cannot stall, so every strobe must be
// captured. Each item makes at most one access to the single-port store (a
// write for a load, a registered read for a drain), which is what allows one
// item per clock. The store needs no clearing after reset.
// Configuration is taken at any time with cfg_ready held high, but must only
// change while no item is in flight.
// ----------------------------------------------------------------------------
module transpose_and_clip_buffer #(
	parameter int DEPTH = tcb_pkg::TCB_DEPTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              mode,
	input  wire logic signed [tcb_pkg::DATA_W-1:0] sample,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tcb_pkg::CFG_IW-1:0]        cfg_index,
	input  wire logic [tcb_pkg::DATA_W-1:0]        cfg_data,
	output logic                                   strobe,
	output logic signed [tcb_pkg::DATA_W-1:0]      value,
	output logic [tcb_pkg::STATUS_W-1:0]           status,
	output logic                                   last
);
	import tcb_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PROD_W-1:0] DEPTH_P = PROD_W'(DEPTH);

	// configuration
	logic [DIM_W-1:0]  rows_q;
	logic [DIM_W-1:0]  cols_q;
	logic [PROD_W-1:0] total_q;
	tcb_limits_t       limits_q;
	logic              cfg_we;
	logic [DIM_W-1:0]  cfg_dim;

	// item register
	logic                     valid_s1;
	logic                     mode_s1;
	logic signed [DATA_W-1:0] sample_s1;

	// sequencing state
	logic [CW-1:0]    load_count_q;
	logic [POS_W-1:0] out_row_q;
	logic [POS_W-1:0] out_col_q;

	logic              load_ok;
	logic              drain_ok;
	logic              restart;
	logic [POS_W-1:0]  row_cur;
	logic [POS_W-1:0]  col_cur;
	logic [PROD_W-1:0] addr_full;
	logic [AW-1:0]     rd_addr;
	logic              is_last;
	logic              row_more;

	// store
	logic [DATA_W-1:0]        grid_mem [DEPTH];
	logic signed [DATA_W-1:0] rd_data_s2;
	tcb_rd_t                  rd_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;
	assign cfg_dim   = dim_of(cfg_data[DIM_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q                 <= DIM_W'(1);
			cols_q                 <= DIM_W'(1);
			total_q                <= PROD_W'(1);
			limits_q.low_limit     <= -16'sd32768;
			limits_q.high_limit    <= 16'sd32767;
			limits_q.fill_value    <= 16'sd0;
			limits_q.ceiling_value <= 16'sd32767;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROW_COUNT: begin
					rows_q  <= cfg_dim;
					total_q <= PROD_W'(cfg_dim) * PROD_W'(cols_q);
				end
				CFG_COL_COUNT: begin
					cols_q  <= cfg_dim;
					total_q <= PROD_W'(rows_q) * PROD_W'(cfg_dim);
				end
				CFG_LOW_LIMIT:     limits_q.low_limit     <= cfg_data;
				CFG_HIGH_LIMIT:    limits_q.high_limit    <= cfg_data;
				CFG_FILL_VALUE:    limits_q.fill_value    <= cfg_data;
				CFG_CEILING_VALUE: limits_q.ceiling_value <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			mode_s1   <= mode;
			sample_s1 <= sample;
		end
	end

	always_comb begin
		load_ok  = valid_s1 && (mode_s1 == MODE_LOAD)
			&& (PROD_W'(load_count_q) < total_q) && (PROD_W'(load_count_q) < DEPTH_P);
		drain_ok = valid_s1 && (mode_s1 == MODE_DRAIN)
			&& (total_q <= DEPTH_P) && (PROD_W'(load_count_q) >= total_q);

		// dimensions changed under a partial drain: start over
		restart = ({1'b0, out_row_q} >= rows_q) || ({1'b0, out_col_q} >= cols_q);
		row_cur = restart ? '0 : out_row_q;
		col_cur = restart ? '0 : out_col_q;

		addr_full = PROD_W'(row_cur) * PROD_W'(cols_q) + PROD_W'(col_cur);
		rd_addr   = (addr_full >= DEPTH_P) ? '0 : addr_full[AW-1:0];

		is_last  = ({1'b0, row_cur} == rows_q - DIM_W'(1))
			&& ({1'b0, col_cur} == cols_q - DIM_W'(1));
		row_more = ({1'b0, row_cur} + DIM_W'(1)) < rows_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
		end else if (load_ok) begin
			load_count_q <= load_count_q + CW'(1);
		end else if (drain_ok) begin
			if (is_last) begin
				out_row_q    <= '0;
				out_col_q    <= '0;
				load_count_q <= '0;
			end else if (row_more) begin
				out_row_q <= row_cur + POS_W'(1);
				out_col_q <= col_cur;
			end else begin
				out_row_q <= '0;
				out_col_q <= col_cur + POS_W'(1);
			end
		end
	end

	// single-port store, registered read
	always_ff @(posedge clk) begin
		if (load_ok) begin
			grid_mem[load_count_q[AW-1:0]] <= sample_s1;
		end else if (drain_ok) begin
			rd_data_s2 <= grid_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s2 <= '0;
		end else begin
			rd_s2.valid <= drain_ok;
			if (drain_ok) begin
				rd_s2.last <= is_last;
			end
		end
	end

	tcb_clip u_clip (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd_s2),
		.rd_data (rd_data_s2),
		.limits  (limits_q),
		.strobe  (strobe),
		.value   (value),
		.status  (status),
		.last    (last)
	);

endmodule
`default_nettype wire
